[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/wfs_pkg.sv]
package wfs_pkg;

    // Neighbor cell codes (code three counts as open)
    localparam logic [1:0] CELL_OPEN = 2'd0;
    localparam logic [1:0] CELL_WALL = 2'd1;
    localparam logic [1:0] CELL_EXIT = 2'd2;

    // Neighbor positions, clockwise from north-west
    localparam logic [2:0] IDX_NW = 3'd0;
    localparam logic [2:0] IDX_N  = 3'd1;
    localparam logic [2:0] IDX_NE = 3'd2;
    localparam logic [2:0] IDX_E  = 3'd3;
    localparam logic [2:0] IDX_SE = 3'd4;
    localparam logic [2:0] IDX_S  = 3'd5;
    localparam logic [2:0] IDX_SW = 3'd6;
    localparam logic [2:0] IDX_W  = 3'd7;

    localparam int NUM_CELLS = 8;

    // Heading modes
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_UP    = 3'd1;
    localparam logic [2:0] MODE_RIGHT = 3'd2;
    localparam logic [2:0] MODE_LEFT  = 3'd3;
    localparam logic [2:0] MODE_DOWN  = 3'd4;
    localparam logic [2:0] MODE_DONE  = 3'd5;

    // Number of live (non-done) modes; bounds the turn chain
    localparam int NUM_LIVE_MODES = 5;

    localparam logic [3:0] DIR_NONE = 4'd0;

    typedef logic [1:0] cell_code_t;
    typedef cell_code_t [NUM_CELLS-1:0] cells_t;

    typedef enum logic [1:0] {
        ACT_MOVE = 2'd0,
        ACT_TURN = 2'd1,
        ACT_STOP = 2'd2,
        ACT_EXIT = 2'd3
    } act_t;

    // Outcome of evaluating one mode on a neighborhood
    typedef struct packed {
        act_t       act;
        logic [2:0] cell_idx;
        logic [2:0] next_mode;
    } decision_t;

    // One result item
    typedef struct packed {
        logic [3:0] move_dir;
        logic [2:0] mode_after;
        logic       exit_reached;
        logic       stopped;
        logic       stuck;
    } result_t;

endpackage

[rtl/core/wfs_cells_if.sv]
interface wfs_cells_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_nw;
    logic [1:0] cell_north;
    logic [1:0] cell_ne;
    logic [1:0] cell_east;
    logic [1:0] cell_se;
    logic [1:0] cell_south;
    logic [1:0] cell_sw;
    logic [1:0] cell_west;

    modport source (
        output valid, cell_nw, cell_north, cell_ne, cell_east,
               cell_se, cell_south, cell_sw, cell_west,
        input  ready
    );

    modport sink (
        input  valid, cell_nw, cell_north, cell_ne, cell_east,
               cell_se, cell_south, cell_sw, cell_west,
        output ready
    );
endinterface

[rtl/core/wfs_move_if.sv]
interface wfs_move_if;
    logic       valid;
    logic       ready;
    logic [3:0] move_dir;
    logic [2:0] mode_after;
    logic       exit_reached;
    logic       stopped;
    logic       stuck;

    modport source (
        output valid, move_dir, mode_after, exit_reached, stopped, stuck,
        input  ready
    );

    modport sink (
        input  valid, move_dir, mode_after, exit_reached, stopped, stuck,
        output ready
    );
endinterface

[rtl/core/wall_follower_step.sv]
// Right-hand wall follower, one move per neighborhood.
//
// Channels: "cells" takes one neighborhood per transaction (eight 2-bit
// cells, 0 open, 1 wall, 2 exit, 3 treated as open). "moves" gives one
// result per neighborhood: move direction, heading mode after the move,
// and the exit_reached / stopped / stuck flags. Both use valid/ready.
//
// A neighborhood taken from "cells" is evaluated out of the input
// register, and its result is written to the output register and offered
// on "moves" from there. Throughput is one transaction per cycle unless
// "moves" stalls; the path between the two registers is the chain of up to
// five mode evaluations (start, up, right, left, down) plus the stuck check.
//
// The heading mode advances when a result is written to the output
// register, so the next neighborhood always sees the updated mode.
// Reset puts the heading mode in start (running east) and empties both
// register stages. When "moves" stalls, the output register holds its
// result and one more neighborhood waits in the input register; "cells"
// then drops ready until the output is taken.
`include "assert_macros.svh"

module wall_follower_step (
    input  logic               clk,
    input  logic               rst_n,
    wfs_cells_if.sink          cells,
    wfs_move_if.source         moves
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    wfs_pkg::cells_t   s1_cells_reg;
    logic [2:0]        mode_reg;
    logic [2:0]        mode_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    wfs_pkg::result_t  out_res_reg;
    wfs_pkg::result_t  res;
    logic              s1_advance;
    logic              in_take;

    // Handshake
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || moves.ready);
    assign cells.ready = !s1_valid_reg || s1_advance;
    assign in_take     = cells.valid && cells.ready;

    // Evaluation of the registered neighborhood
    wfs_chain u_chain (
        .mode   (mode_reg),
        .cells  (s1_cells_reg),
        .result (res)
    );

    // Next-state logic
    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !moves.ready);
        mode_next      = s1_advance ? res.mode_after : mode_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= wfs_pkg::MODE_START;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cells_reg[wfs_pkg::IDX_NW] <= cells.cell_nw;
            s1_cells_reg[wfs_pkg::IDX_N]  <= cells.cell_north;
            s1_cells_reg[wfs_pkg::IDX_NE] <= cells.cell_ne;
            s1_cells_reg[wfs_pkg::IDX_E]  <= cells.cell_east;
            s1_cells_reg[wfs_pkg::IDX_SE] <= cells.cell_se;
            s1_cells_reg[wfs_pkg::IDX_S]  <= cells.cell_south;
            s1_cells_reg[wfs_pkg::IDX_SW] <= cells.cell_sw;
            s1_cells_reg[wfs_pkg::IDX_W]  <= cells.cell_west;
        end
        if (s1_advance)
            out_res_reg <= res;
    end

    // Output channel
    assign moves.valid        = out_valid_reg;
    assign moves.move_dir     = out_res_reg.move_dir;
    assign moves.mode_after   = out_res_reg.mode_after;
    assign moves.exit_reached = out_res_reg.exit_reached;
    assign moves.stopped      = out_res_reg.stopped;
    assign moves.stuck        = out_res_reg.stuck;

    // Checks
    `ASSERT_ALWAYS(a_mode_range, clk, rst_n, mode_reg <= wfs_pkg::MODE_DONE)
    `ASSERT_NEXT(a_done_sticks, clk, rst_n, mode_reg == wfs_pkg::MODE_DONE, mode_reg == wfs_pkg::MODE_DONE)
    `ASSERT_NEXT(a_mode_holds, clk, rst_n, !s1_advance, $stable(mode_reg))
    `ASSERT_IMPLIES(a_flags_excl, clk, rst_n, out_valid_reg, $onehot0({out_res_reg.exit_reached, out_res_reg.stopped, out_res_reg.stuck}))
    `ASSERT_IMPLIES(a_end_done, clk, rst_n, out_valid_reg && (out_res_reg.stopped || out_res_reg.stuck), out_res_reg.mode_after == wfs_pkg::MODE_DONE && out_res_reg.move_dir == wfs_pkg::DIR_NONE)

endmodule

[rtl/core/wfs_decide.sv]
// Right-hand rule for one heading mode on one neighborhood.
module wfs_decide (
    input  logic [2:0]                         mode,
    input  logic [wfs_pkg::NUM_CELLS-1:0]      wall,
    input  logic                               exit_east,
    input  logic                               exit_near,
    output wfs_pkg::decision_t                 decision
);

    logic nw, n, ne, e, se, s, sw, w;

    assign nw = wall[wfs_pkg::IDX_NW];
    assign n  = wall[wfs_pkg::IDX_N];
    assign ne = wall[wfs_pkg::IDX_NE];
    assign e  = wall[wfs_pkg::IDX_E];
    assign se = wall[wfs_pkg::IDX_SE];
    assign s  = wall[wfs_pkg::IDX_S];
    assign sw = wall[wfs_pkg::IDX_SW];
    assign w  = wall[wfs_pkg::IDX_W];

    always_comb
    begin
        decision.act       = wfs_pkg::ACT_STOP;
        decision.cell_idx  = wfs_pkg::IDX_NW;
        decision.next_mode = mode;
        unique case (mode)
            wfs_pkg::MODE_START:
            begin
                // run east until a wall or the exit
                priority if (!e && !exit_east)
                begin
                    decision.act      = wfs_pkg::ACT_MOVE;
                    decision.cell_idx = wfs_pkg::IDX_E;
                end
                else if (exit_near)
                    decision.act = wfs_pkg::ACT_EXIT;
                else
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_UP;
                end
            end
            wfs_pkg::MODE_UP:
            begin
                priority if (e && !n)
                begin
                    decision.act      = exit_near ? wfs_pkg::ACT_EXIT : wfs_pkg::ACT_MOVE;
                    decision.cell_idx = wfs_pkg::IDX_N;
                end
                else if (e && n && !w)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_LEFT;
                end
                else if (se && !e)
                begin
                    decision.act       = wfs_pkg::ACT_MOVE;
                    decision.cell_idx  = wfs_pkg::IDX_E;
                    decision.next_mode = wfs_pkg::MODE_RIGHT;
                end
                else if (w && n && e)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_DOWN;
                end
                else
                    decision.act = wfs_pkg::ACT_STOP;
            end
            wfs_pkg::MODE_RIGHT:
            begin
                priority if (s && !e)
                begin
                    decision.act      = exit_near ? wfs_pkg::ACT_EXIT : wfs_pkg::ACT_MOVE;
                    decision.cell_idx = wfs_pkg::IDX_E;
                end
                else if (sw && !s)
                begin
                    decision.act       = wfs_pkg::ACT_MOVE;
                    decision.cell_idx  = wfs_pkg::IDX_S;
                    decision.next_mode = wfs_pkg::MODE_DOWN;
                end
                else if (s && e && !n)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_UP;
                end
                else if (s && e && n)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_LEFT;
                end
                else
                    decision.act = wfs_pkg::ACT_STOP;
            end
            wfs_pkg::MODE_LEFT:
            begin
                priority if (n && !w)
                begin
                    decision.act      = exit_near ? wfs_pkg::ACT_EXIT : wfs_pkg::ACT_MOVE;
                    decision.cell_idx = wfs_pkg::IDX_W;
                end
                else if (n && w && !s)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_DOWN;
                end
                else if (!n && ne)
                begin
                    decision.act       = wfs_pkg::ACT_MOVE;
                    decision.cell_idx  = wfs_pkg::IDX_N;
                    decision.next_mode = wfs_pkg::MODE_UP;
                end
                else if (s && w && n)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_RIGHT;
                end
                else
                    decision.act = wfs_pkg::ACT_STOP;
            end
            wfs_pkg::MODE_DOWN:
            begin
                priority if (w && !s)
                begin
                    decision.act      = exit_near ? wfs_pkg::ACT_EXIT : wfs_pkg::ACT_MOVE;
                    decision.cell_idx = wfs_pkg::IDX_S;
                end
                else if (w && s && !e)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_RIGHT;
                end
                else if (!w && nw)
                begin
                    decision.act       = wfs_pkg::ACT_MOVE;
                    decision.cell_idx  = wfs_pkg::IDX_W;
                    decision.next_mode = wfs_pkg::MODE_LEFT;
                end
                else if (e && s && w)
                begin
                    decision.act       = wfs_pkg::ACT_TURN;
                    decision.next_mode = wfs_pkg::MODE_UP;
                end
                else
                    decision.act = wfs_pkg::ACT_STOP;
            end
            default:
                decision.act = wfs_pkg::ACT_STOP;
        endcase
    end

endmodule

[rtl/core/wfs_chain.sv]
// Chain of mode evaluations on one neighborhood; turns without a move
// pass to the next evaluation, a revisited mode ends the walk as stuck.
module wfs_chain (
    input  logic [2:0]        mode,
    input  wfs_pkg::cells_t   cells,
    output wfs_pkg::result_t  result
);

    localparam int Stages = wfs_pkg::NUM_LIVE_MODES;

    logic [wfs_pkg::NUM_CELLS-1:0] wall;
    logic [wfs_pkg::NUM_CELLS-1:0] is_exit;
    logic                          exit_near;
    logic [2:0]                    first_exit;

    logic                                   st_active  [Stages+1];
    logic [2:0]                             st_mode    [Stages+1];
    logic [wfs_pkg::NUM_LIVE_MODES-1:0]     st_visited [Stages+1];
    wfs_pkg::result_t                       st_res     [Stages+1];
    wfs_pkg::decision_t                     dec        [Stages];

    // Cell classification and first exit in NW..W order
    always_comb
    begin
        first_exit = wfs_pkg::IDX_NW;
        for (int i = 0; i < wfs_pkg::NUM_CELLS; i++)
        begin
            wall[i]    = (cells[i] == wfs_pkg::CELL_WALL);
            is_exit[i] = (cells[i] == wfs_pkg::CELL_EXIT);
        end
        for (int i = wfs_pkg::NUM_CELLS - 1; i >= 0; i--)
        begin
            if (is_exit[i])
                first_exit = 3'(i);
        end
    end

    assign exit_near = |is_exit;

    // Chain entry: done or invalid modes skip evaluation
    assign st_active[0]  = (mode < wfs_pkg::MODE_DONE);
    assign st_mode[0]    = mode;
    assign st_visited[0] = '0;
    assign st_res[0]     = '{move_dir: wfs_pkg::DIR_NONE, mode_after: wfs_pkg::MODE_DONE,
                             exit_reached: 1'b0, stopped: 1'b0, stuck: 1'b0};

    for (genvar g = 0; g < Stages; g++)
    begin : g_stage
        wfs_decide u_decide (
            .mode      (st_mode[g]),
            .wall      (wall),
            .exit_east (is_exit[wfs_pkg::IDX_E]),
            .exit_near (exit_near),
            .decision  (dec[g])
        );

        always_comb
        begin
            st_active[g+1]  = 1'b0;
            st_mode[g+1]    = st_mode[g];
            st_visited[g+1] = st_visited[g];
            st_res[g+1]     = st_res[g];
            if (st_active[g])
            begin
                if (st_visited[g][st_mode[g]])
                begin
                    // mode seen before in this transaction
                    st_res[g+1].stuck      = 1'b1;
                    st_res[g+1].mode_after = wfs_pkg::MODE_DONE;
                end
                else
                begin
                    st_visited[g+1][st_mode[g]] = 1'b1;
                    unique case (dec[g].act)
                        wfs_pkg::ACT_TURN:
                        begin
                            st_active[g+1] = 1'b1;
                            st_mode[g+1]   = dec[g].next_mode;
                        end
                        wfs_pkg::ACT_MOVE:
                        begin
                            st_res[g+1].move_dir     = 4'(dec[g].cell_idx) + 4'd1;
                            st_res[g+1].exit_reached = is_exit[dec[g].cell_idx];
                            st_res[g+1].mode_after   = dec[g].next_mode;
                        end
                        wfs_pkg::ACT_EXIT:
                        begin
                            st_res[g+1].move_dir     = 4'(first_exit) + 4'd1;
                            st_res[g+1].exit_reached = 1'b1;
                            st_res[g+1].mode_after   = wfs_pkg::MODE_DONE;
                        end
                        wfs_pkg::ACT_STOP:
                        begin
                            st_res[g+1].stopped    = 1'b1;
                            st_res[g+1].mode_after = wfs_pkg::MODE_DONE;
                        end
                        default:
                        begin
                            st_res[g+1].stopped    = 1'b1;
                            st_res[g+1].mode_after = wfs_pkg::MODE_DONE;
                        end
                    endcase
                end
            end
        end
    end

    // Still turning after every live mode: loop without a move
    always_comb
    begin
        result = st_res[Stages];
        if (st_active[Stages])
        begin
            result.stuck      = 1'b1;
            result.mode_after = wfs_pkg::MODE_DONE;
        end
    end

endmodule
